// ===== rtl/core/histogram_statistics_core_macros.svh =====
// Assertion macros used by the histogram statistics core.
`ifndef HISTOGRAM_STATISTICS_CORE_MACROS_SVH
`define HISTOGRAM_STATISTICS_CORE_MACROS_SVH

// Check that the consequence holds in the same cycle as the antecedent.
`define HSTAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequence holds in the cycle after the antecedent.
`define HSTAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hstat_pkg.sv =====
package hstat_pkg;

  // Defaults for the top-level parameters
  localparam int NumBinsDef   = 256;
  localparam int CountBitsDef = 32;

  // Fixed result field widths
  localparam int FracBits = 16;
  localparam int MeanW    = 24;
  localparam int ValW     = 8;
  localparam int MedW     = 9;

  // Status of a multi-cycle unit
  typedef struct packed {
    logic busy;
  } unit_st_t;

endpackage

// ===== rtl/core/histogram_statistics_core.sv =====
// Histogram statistics core.
// Input: one bin count per request, bin 0 first, taken on a clock edge with
// start_i high and busy_o low; last_bin_i marks the final bin. Bins beyond
// NUM_BINS are dropped, but their last flag still closes the histogram.
// Bins may be loaded back to back. After the last bin busy_o stays high while
// the stored counts are walked (one bin read per cycle from the bin memory)
// and, in parallel, a bit-serial divider forms the mean. The result is
// registered once both the walk and the divider are done.
// Output: valid_o is high for exactly one cycle with min, max, mean (Q.16),
// twice the median, mode and the empty flag; the receiver cannot stall, and
// the next histogram may start in that same cycle.
// Reset clears all accumulators and control; the bin memory needs no clearing
// as only bins of the current histogram are ever read.
`include "histogram_statistics_core_macros.svh"

module histogram_statistics_core #(
  parameter int NUM_BINS   = hstat_pkg::NumBinsDef,
  parameter int COUNT_BITS = hstat_pkg::CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] bin_count_i,
  input  logic        last_bin_i,
  output logic        valid_o,
  output logic [7:0]  min_value_o,
  output logic [7:0]  max_value_o,
  output logic [23:0] mean_q16_o,
  output logic [8:0]  median_doubled_o,
  output logic [7:0]  mode_value_o,
  output logic        empty_res_o
);

  localparam int IdxW  = $clog2(NUM_BINS);
  localparam int NbW   = $clog2(NUM_BINS + 1);
  localparam int TotW  = COUNT_BITS + IdxW;
  localparam int SumW  = COUNT_BITS + 2 * IdxW;
  localparam int ValW  = hstat_pkg::ValW;
  localparam int MedW  = hstat_pkg::MedW;
  localparam int MeanW = hstat_pkg::MeanW;

  typedef enum logic [1:0] {ST_LOAD, ST_KICK, ST_RUN} state_e;

  state_e              state_q;
  logic                accept, kick;
  logic                wr_en;
  logic [IdxW-1:0]     wr_addr, lowest, highest, mode, lo, hi;
  logic [NbW-1:0]      next_bin;
  logic [SumW-1:0]     sum;
  logic [TotW-1:0]     total, rank_lo, rank_hi;
  logic                seen;
  logic [TotW:0]       total_p1;
  hstat_pkg::unit_st_t div_st, med_st;
  logic [MeanW-1:0]    quot;
  logic [IdxW-1:0]     lowest_q, highest_q, mode_q;
  logic                empty_q;
  logic                valid_q, empty_out_q;
  logic [ValW-1:0]     min_q, max_q, modev_q;
  logic [MeanW-1:0]    mean_q;
  logic [MedW-1:0]     med_q;
  logic [IdxW:0]       med_sum;

  assign accept   = start_i && (state_q == ST_LOAD);
  assign kick     = state_q == ST_KICK;
  assign total_p1 = {1'b0, total} + 1'b1;
  assign rank_lo  = total_p1[TotW:1];
  assign rank_hi  = (total >> 1) + 1'b1;
  assign med_sum  = {1'b0, lo} + {1'b0, hi};

  hstat_accum #(.NUM_BINS(NUM_BINS), .COUNT_BITS(COUNT_BITS)) u_accum (
    .clk_i, .rst_ni,
    .load_i    (accept),
    .clear_i   (kick),
    .count_i   (bin_count_i[COUNT_BITS-1:0]),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .next_bin_o(next_bin),
    .sum_o     (sum),
    .total_o   (total),
    .lowest_o  (lowest),
    .highest_o (highest),
    .mode_o    (mode),
    .seen_o    (seen)
  );

  hstat_median #(.NUM_BINS(NUM_BINS), .COUNT_BITS(COUNT_BITS)) u_median (
    .clk_i, .rst_ni,
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(bin_count_i[COUNT_BITS-1:0]),
    .start_i  (kick),
    .count_i  (next_bin),
    .rank_lo_i(rank_lo),
    .rank_hi_i(rank_hi),
    .highest_i(highest),
    .st_o     (med_st),
    .lo_o     (lo),
    .hi_o     (hi)
  );

  hstat_div #(.NUM_BINS(NUM_BINS), .COUNT_BITS(COUNT_BITS)) u_div (
    .clk_i, .rst_ni,
    .start_i   (kick),
    .dividend_i(sum),
    .divisor_i (total),
    .st_o      (div_st),
    .quot_o    (quot)
  );

  // Sequence load, launch and finish; register the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      valid_q     <= 1'b0;
      empty_out_q <= 1'b0;
      empty_q     <= 1'b0;
      lowest_q    <= '0;
      highest_q   <= '0;
      mode_q      <= '0;
      min_q       <= '0;
      max_q       <= '0;
      modev_q     <= '0;
      mean_q      <= '0;
      med_q       <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_LOAD: begin
          if (accept && last_bin_i) begin
            state_q <= ST_KICK;
          end
        end
        ST_KICK: begin
          lowest_q  <= lowest;
          highest_q <= highest;
          mode_q    <= mode;
          empty_q   <= !seen || (total == '0);
          state_q   <= ST_RUN;
        end
        ST_RUN: begin
          if (!div_st.busy && !med_st.busy) begin
            valid_q     <= 1'b1;
            empty_out_q <= empty_q;
            min_q       <= empty_q ? '0 : ValW'(lowest_q);
            max_q       <= empty_q ? '0 : ValW'(highest_q);
            modev_q     <= empty_q ? '0 : ValW'(mode_q);
            mean_q      <= empty_q ? '0 : quot;
            med_q       <= empty_q ? '0 : MedW'(med_sum);
            state_q     <= ST_LOAD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign busy_o           = state_q != ST_LOAD;
  assign valid_o          = valid_q;
  assign min_value_o      = min_q;
  assign max_value_o      = max_q;
  assign mean_q16_o       = mean_q;
  assign median_doubled_o = med_q;
  assign mode_value_o     = modev_q;
  assign empty_res_o      = empty_out_q;

  `HSTAT_ASSERT_NEXT(a_last_goes_busy, start_i && !busy_o && last_bin_i, busy_o, "no busy after last bin")
  `HSTAT_ASSERT_NOW(a_result_idle, valid_o, !busy_o, "result while busy")
  `HSTAT_ASSERT_NOW(a_empty_zero, valid_o && empty_res_o, (min_value_o == 8'd0) && (max_value_o == 8'd0) && (mean_q16_o == 24'd0) && (median_doubled_o == 9'd0) && (mode_value_o == 8'd0), "empty result not zero")

endmodule

// ===== rtl/core/hstat_accum.sv =====
module hstat_accum #(
  parameter int NUM_BINS   = hstat_pkg::NumBinsDef,
  parameter int COUNT_BITS = hstat_pkg::CountBitsDef,
  localparam int IdxW = $clog2(NUM_BINS),
  localparam int NbW  = $clog2(NUM_BINS + 1),
  localparam int TotW = COUNT_BITS + IdxW,
  localparam int SumW = COUNT_BITS + 2 * IdxW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic                  clear_i,
  input  logic [COUNT_BITS-1:0] count_i,
  output logic                  wr_en_o,
  output logic [IdxW-1:0]       wr_addr_o,
  output logic [NbW-1:0]        next_bin_o,
  output logic [SumW-1:0]       sum_o,
  output logic [TotW-1:0]       total_o,
  output logic [IdxW-1:0]       lowest_o,
  output logic [IdxW-1:0]       highest_o,
  output logic [IdxW-1:0]       mode_o,
  output logic                  seen_o
);

  logic [NbW-1:0]        next_bin_q, next_bin_d;
  logic [SumW-1:0]       sum_q, sum_d;
  logic [TotW-1:0]       total_q, total_d;
  logic [IdxW-1:0]       lowest_q, lowest_d, highest_q, highest_d, mode_q, mode_d;
  logic [COUNT_BITS-1:0] mode_cnt_q, mode_cnt_d;
  logic                  seen_q, seen_d;
  logic [IdxW-1:0]       idx;
  logic                  in_range;
  logic [IdxW+COUNT_BITS-1:0] prod;

  assign idx      = next_bin_q[IdxW-1:0];
  assign in_range = next_bin_q < NbW'(NUM_BINS);
  assign prod     = idx * count_i;

  // Clear the running statistics, or fold one in-range bin into them
  always_comb begin
    next_bin_d = next_bin_q;
    sum_d      = sum_q;
    total_d    = total_q;
    lowest_d   = lowest_q;
    highest_d  = highest_q;
    mode_d     = mode_q;
    mode_cnt_d = mode_cnt_q;
    seen_d     = seen_q;
    if (clear_i) begin
      next_bin_d = '0;
      sum_d      = '0;
      total_d    = '0;
      lowest_d   = '0;
      highest_d  = '0;
      mode_d     = '0;
      mode_cnt_d = '0;
      seen_d     = 1'b0;
    end else if (load_i && in_range) begin
      if (count_i != '0) begin
        if (!seen_q) begin
          lowest_d = idx;
        end
        highest_d = idx;
        seen_d    = 1'b1;
        sum_d     = sum_q + SumW'(prod);
        total_d   = total_q + TotW'(count_i);
        if (count_i > mode_cnt_q) begin
          mode_cnt_d = count_i;
          mode_d     = idx;
        end
      end
      next_bin_d = next_bin_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_bin_q <= '0;
      sum_q      <= '0;
      total_q    <= '0;
      lowest_q   <= '0;
      highest_q  <= '0;
      mode_q     <= '0;
      mode_cnt_q <= '0;
      seen_q     <= 1'b0;
    end else begin
      next_bin_q <= next_bin_d;
      sum_q      <= sum_d;
      total_q    <= total_d;
      lowest_q   <= lowest_d;
      highest_q  <= highest_d;
      mode_q     <= mode_d;
      mode_cnt_q <= mode_cnt_d;
      seen_q     <= seen_d;
    end
  end

  assign wr_en_o    = load_i && in_range;
  assign wr_addr_o  = idx;
  assign next_bin_o = next_bin_q;
  assign sum_o      = sum_q;
  assign total_o    = total_q;
  assign lowest_o   = lowest_q;
  assign highest_o  = highest_q;
  assign mode_o     = mode_q;
  assign seen_o     = seen_q;

endmodule

// ===== rtl/core/hstat_median.sv =====
module hstat_median #(
  parameter int NUM_BINS   = hstat_pkg::NumBinsDef,
  parameter int COUNT_BITS = hstat_pkg::CountBitsDef,
  localparam int IdxW = $clog2(NUM_BINS),
  localparam int NbW  = $clog2(NUM_BINS + 1),
  localparam int TotW = COUNT_BITS + IdxW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [IdxW-1:0]       wr_addr_i,
  input  logic [COUNT_BITS-1:0] wr_data_i,
  input  logic                  start_i,
  input  logic [NbW-1:0]        count_i,
  input  logic [TotW-1:0]       rank_lo_i,
  input  logic [TotW-1:0]       rank_hi_i,
  input  logic [IdxW-1:0]       highest_i,
  output hstat_pkg::unit_st_t   st_o,
  output logic [IdxW-1:0]       lo_o,
  output logic [IdxW-1:0]       hi_o
);

  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic [NbW-1:0]        addr_q, cnt_q;
  logic [IdxW-1:0]       data_idx_q, lo_q, hi_q;
  logic [COUNT_BITS-1:0] data_q;
  logic                  issue_q, data_v_q, active_q, found_lo_q, found_hi_q;
  logic [TotW-1:0]       cum_q, cum_d, rank_lo_q, rank_hi_q;

  assign cum_d = cum_q + TotW'(data_q);

  // Store bins as they arrive
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one stored bin per cycle
  always_ff @(posedge clk_i) begin
    data_q     <= mem[addr_q[IdxW-1:0]];
    data_idx_q <= addr_q[IdxW-1:0];
  end

  // Walk the loaded bins, accumulating counts and noting where each median rank is first reached
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '0;
      cnt_q      <= '0;
      issue_q    <= 1'b0;
      data_v_q   <= 1'b0;
      active_q   <= 1'b0;
      found_lo_q <= 1'b0;
      found_hi_q <= 1'b0;
      cum_q      <= '0;
      rank_lo_q  <= '0;
      rank_hi_q  <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
    end else if (start_i) begin
      addr_q     <= '0;
      cnt_q      <= count_i;
      issue_q    <= count_i != '0;
      data_v_q   <= 1'b0;
      active_q   <= 1'b1;
      found_lo_q <= 1'b0;
      found_hi_q <= 1'b0;
      cum_q      <= '0;
      rank_lo_q  <= rank_lo_i;
      rank_hi_q  <= rank_hi_i;
      lo_q       <= highest_i;
      hi_q       <= highest_i;
    end else begin
      data_v_q <= issue_q;
      if (issue_q) begin
        addr_q <= addr_q + 1'b1;
        if (addr_q + 1'b1 == cnt_q) begin
          issue_q <= 1'b0;
        end
      end
      if (data_v_q) begin
        cum_q <= cum_d;
        if (!found_lo_q && cum_d >= rank_lo_q) begin
          found_lo_q <= 1'b1;
          lo_q       <= data_idx_q;
        end
        if (!found_hi_q && cum_d >= rank_hi_q) begin
          found_hi_q <= 1'b1;
          hi_q       <= data_idx_q;
        end
      end
      if (!issue_q && !data_v_q) begin
        active_q <= 1'b0;
      end
    end
  end

  assign st_o.busy = active_q;
  assign lo_o      = lo_q;
  assign hi_o      = hi_q;

endmodule

// ===== rtl/core/hstat_div.sv =====
module hstat_div #(
  parameter int NUM_BINS   = hstat_pkg::NumBinsDef,
  parameter int COUNT_BITS = hstat_pkg::CountBitsDef,
  localparam int IdxW = $clog2(NUM_BINS),
  localparam int TotW = COUNT_BITS + IdxW,
  localparam int SumW = COUNT_BITS + 2 * IdxW,
  localparam int DvdW = SumW + hstat_pkg::FracBits,
  localparam int CntW = $clog2(DvdW + 1),
  localparam int MeanW = hstat_pkg::MeanW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SumW-1:0]     dividend_i,
  input  logic [TotW-1:0]     divisor_i,
  output hstat_pkg::unit_st_t st_o,
  output logic [MeanW-1:0]    quot_o
);

  logic [DvdW-1:0]  dvd_q;
  logic [TotW-1:0]  dsr_q, rem_q;
  logic [MeanW-1:0] quot_q;
  logic [CntW-1:0]  cnt_q;
  logic             active_q;
  logic [TotW:0]    rem_sh, rem_sub;
  logic             qbit;

  // Shift in one dividend bit and try to subtract the divisor
  assign rem_sh  = {rem_q, dvd_q[DvdW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign qbit    = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q    <= '0;
      dsr_q    <= '0;
      rem_q    <= '0;
      quot_q   <= '0;
      cnt_q    <= '0;
      active_q <= 1'b0;
    end else if (start_i) begin
      dvd_q    <= {dividend_i, hstat_pkg::FracBits'(0)};
      dsr_q    <= divisor_i;
      rem_q    <= '0;
      quot_q   <= '0;
      cnt_q    <= CntW'(DvdW);
      active_q <= 1'b1;
    end else if (active_q) begin
      dvd_q  <= {dvd_q[DvdW-2:0], 1'b0};
      rem_q  <= qbit ? rem_sub[TotW-1:0] : rem_sh[TotW-1:0];
      quot_q <= {quot_q[MeanW-2:0], qbit};
      cnt_q  <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        active_q <= 1'b0;
      end
    end
  end

  assign st_o.busy = active_q;
  assign quot_o    = quot_q;

endmodule

// ===== tb/histogram_statistics_checker.sv =====
`timescale 1ns / 100ps

module histogram_statistics_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [31:0] bin_count_i,
  input  logic        last_bin_i,
  input  logic        valid_i,
  input  logic [7:0]  min_value_i,
  input  logic [7:0]  max_value_i,
  input  logic [23:0] mean_q16_i,
  input  logic [8:0]  median_doubled_i,
  input  logic [7:0]  mode_value_i,
  input  logic        empty_res_i,
  output int          errors_o,
  output int          pending_o,
  output int          results_o,
  output int          empties_o
);

  localparam int Bins = hstat_pkg::NumBinsDef;

  typedef struct packed {
    logic [7:0]  min_v;
    logic [7:0]  max_v;
    logic [23:0] mean;
    logic [8:0]  med2;
    logic [7:0]  mode_v;
    logic        empty;
  } hist_stats_t;

  // Shadow copy of the block's histogram state
  logic [31:0] shadow_bins [Bins];
  int unsigned bins_loaded;
  logic [47:0] sum_weighted;
  logic [39:0] sum_samples;
  logic [7:0]  first_used, last_used, peak_bin;
  logic        any_used;
  logic [31:0] peak_count;

  hist_stats_t stats_q[$];

  initial begin
    errors_o = 0;
    results_o = 0;
    empties_o = 0;
    bins_loaded = 0;
    sum_weighted = '0;
    sum_samples = '0;
    first_used = '0;
    last_used = '0;
    peak_bin = '0;
    any_used = 1'b0;
    peak_count = '0;
  end

  assign pending_o = stats_q.size();

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t checker: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    errors_o++;
  endtask

  task automatic check_field(input string what, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Walk the loaded bins to find which one holds the sample of this rank
  function automatic logic [7:0] bin_at_rank(input logic [63:0] rank);
    logic [63:0] running;
    running = '0;
    for (int i = 0; i < bins_loaded; i++) begin
      running += shadow_bins[i];
      if (running >= rank) return i[7:0];
    end
    return last_used;
  endfunction

  // Fold one request into the shadow state; queue the stats on the last bin
  task automatic predict_request(input logic [31:0] cnt, input logic is_last);
    hist_stats_t s;
    logic [63:0] total, quot, rem, frac, mean_full;
    logic [8:0]  lo, hi;
    if (bins_loaded < Bins) begin
      shadow_bins[bins_loaded] = cnt;
      if (cnt != 0) begin
        if (!any_used) first_used = bins_loaded[7:0];
        last_used = bins_loaded[7:0];
        any_used = 1'b1;
        sum_weighted += 48'(bins_loaded) * 48'(cnt);
        sum_samples += 40'(cnt);
        if (cnt > peak_count) begin
          peak_count = cnt;
          peak_bin = bins_loaded[7:0];
        end
      end
      bins_loaded++;
    end
    if (!is_last) return;
    s = '0;
    if (!any_used || sum_samples == 0) begin
      s.empty = 1'b1;
    end else begin
      total = 64'(sum_samples);
      quot = 64'(sum_weighted) / total;
      rem = 64'(sum_weighted) % total;
      frac = (rem << 16) / total;
      mean_full = (quot << 16) | frac;
      lo = 9'(bin_at_rank((total + 1) / 2));
      hi = 9'(bin_at_rank(total / 2 + 1));
      s.min_v = first_used;
      s.max_v = last_used;
      s.mean = mean_full[23:0];
      s.med2 = lo + hi;
      s.mode_v = peak_bin;
    end
    stats_q = {stats_q, s};
    bins_loaded = 0;
    sum_weighted = '0;
    sum_samples = '0;
    first_used = '0;
    last_used = '0;
    peak_bin = '0;
    any_used = 1'b0;
    peak_count = '0;
  endtask

  // Compare results first, then take the request of the same edge
  always @(posedge clk_i) begin
    hist_stats_t want;
    if (rst_ni && valid_i) begin
      if (stats_q.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 0);
      end else begin
        want = stats_q.pop_front();
        results_o++;
        if (want.empty) empties_o++;
        check_field("min_value", min_value_i, want.min_v);
        check_field("max_value", max_value_i, want.max_v);
        check_field("mean_q16", mean_q16_i, want.mean);
        check_field("median_doubled", median_doubled_i, want.med2);
        check_field("mode_value", mode_value_i, want.mode_v);
        check_field("empty_res", empty_res_i, want.empty);
      end
    end
    if (rst_ni && start_i && !busy_i) predict_request(bin_count_i, last_bin_i);
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [31:0] bin_count_i;
  logic        last_bin_i;
  logic        valid_o;
  logic [7:0]  min_value_o, max_value_o, mode_value_o;
  logic [23:0] mean_q16_o;
  logic [8:0]  median_doubled_o;
  logic        empty_res_o;

  int errors, pending, results, empties;
  int requests_sent;
  bit no_gaps;

  histogram_statistics_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .bin_count_i, .last_bin_i, .valid_o,
    .min_value_o, .max_value_o, .mean_q16_o, .median_doubled_o, .mode_value_o,
    .empty_res_o
  );

  histogram_statistics_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .bin_count_i, .last_bin_i,
    .valid_i(valid_o), .min_value_i(min_value_o), .max_value_i(max_value_o),
    .mean_q16_i(mean_q16_o), .median_doubled_i(median_doubled_o),
    .mode_value_i(mode_value_o), .empty_res_i(empty_res_o),
    .errors_o(errors), .pending_o(pending), .results_o(results), .empties_o(empties)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hold the request until the block takes it, idling first where drawn
  task automatic send_bin(input logic [31:0] cnt, input logic is_last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(12);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    bin_count_i <= cnt;
    last_bin_i <= is_last;
    do @(posedge clk_i); while (busy_o);
    requests_sent++;
  endtask

  // Mostly empty or small bins, some full-width and saturated counts
  function automatic logic [31:0] draw_count();
    int pick;
    pick = $urandom_range(9);
    if (pick < 3) return 32'd0;
    if (pick < 7) return 32'($urandom_range(1, 20));
    if (pick < 8) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic send_histogram(input int len);
    for (int i = 0; i < len; i++) send_bin(draw_count(), i == len - 1);
  endtask

  initial begin
    int len;
    rst_ni = 1'b0;
    start_i = 1'b0;
    bin_count_i = '0;
    last_bin_i = 1'b0;
    requests_sent = 0;
    no_gaps = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty, single bin, leading zeros, ties, gapped even median, saturation
    send_bin(32'd0, 1'b1);
    send_bin(32'd5, 1'b1);
    send_bin(32'd0, 1'b0); send_bin(32'd0, 1'b0); send_bin(32'd7, 1'b1);
    send_bin(32'd3, 1'b0); send_bin(32'd3, 1'b1);
    send_bin(32'd1, 1'b0); send_bin(32'd0, 1'b0); send_bin(32'd0, 1'b0);
    send_bin(32'd1, 1'b1);
    send_bin(32'hFFFF_FFFF, 1'b0); send_bin(32'hFFFF_FFFF, 1'b0); send_bin(32'd2, 1'b1);
    send_bin(32'd0, 1'b0); send_bin(32'd0, 1'b0); send_bin(32'd0, 1'b1);
    send_bin(32'hFFFF_FFFF, 1'b0); send_bin(32'h8000_0000, 1'b0);
    send_bin(32'h7FFF_FFFF, 1'b1);

    // Random histograms; a full-size and an overlong one come first
    for (int h = 0; requests_sent < 1500; h++) begin
      no_gaps = ($urandom_range(2) == 0);
      if (h == 0) len = 256;
      else if (h == 1) len = 270;
      else if ($urandom_range(39) == 0) len = $urandom_range(240, 262);
      else len = $urandom_range(1, 20);
      send_histogram(len);
    end
    start_i <= 1'b0;

    wait (pending == 0);
    repeat (300) @(posedge clk_i);
    $display("Sent %0d bin requests; checked %0d histogram results, %0d of them empty.",
             requests_sent, results, empties);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
